// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RIFF chunk walker RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define RCW_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");

// A condition that, once true, forces another condition in the next cycle.
`define RCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle consequence missing");

// A condition that forces another condition in the same cycle.
`define RCW_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle consequence missing");

`endif

// ===== hdl/rcw_pkg.sv =====
// Shared constants, tag table and result type of the RIFF chunk walker.
// Depends on nothing; every file but rcw_byte_if and assert_macros.svh imports it.
package rcw_pkg;

  localparam int POS_BITS   = 32;
  localparam int TAG_COUNT  = 38;
  localparam int TABLE_SIZE = 38;
  localparam int TAG_LIMIT  = (TAG_COUNT < TABLE_SIZE) ? TAG_COUNT : TABLE_SIZE;

  localparam int CFG_W     = 32;
  localparam int IDX_W     = 6;
  localparam int OUT_POS_W = 32;
  // Chunk offsets stay within the file length plus a header, so two bits of
  // headroom above the wider of the position and the length are enough.
  localparam int ADDR_W    = ((POS_BITS > CFG_W) ? POS_BITS : CFG_W) + 2;
  localparam int HDR_BYTES = 12;
  localparam int LEVELS    = 3;

  localparam logic [31:0] FCC_RIFF = "RIFF";
  localparam logic [31:0] FCC_LIST = "LIST";
  localparam logic [31:0] FCC_INFO = "INFO";

  // Entry 0 is the signature tag, entry 1 the XMP tag, the rest INFO tags.
  localparam logic [31:0] TAG_TABLE [TABLE_SIZE] = '{
    32'h5345_414C, "XMP ", "IARL", "IART", "ICDS", "ICMS", "ICMT", "ICOP",
    "ICRD", "ICRP", "IDIM", "IDIT", "IDPI", "IEDT", "IENG", "IGNR",
    "IKEY", "ILGT", "IMED", "IMUS", "INAM", "IPDS", "IPLT", "IPRD",
    "IPRO", "ISBJ", "ISFT", "ISGN", "ISHP", "ISMP", "ISRC", "ISRF",
    "ISTD", "ISTR", "ITCH", "IWEB", "IWRI", "IWRI"
  };

  typedef struct packed {
    logic [IDX_W-1:0]     tag_index;
    logic [OUT_POS_W-1:0] data_start;
    logic [OUT_POS_W-1:0] data_end;
  } rcw_result_t;

endpackage

// ===== hdl/rcw_byte_if.sv =====
// Input channel of the RIFF chunk walker: one file byte per beat.
// Depends on nothing.
interface rcw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hdl/rcw_result_if.sv =====
// Result channel of the RIFF chunk walker: one tagged chunk range per beat.
// Widths come from rcw_pkg.
interface rcw_result_if;
  import rcw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [IDX_W-1:0]     tag_index;
  logic [OUT_POS_W-1:0] data_start;
  logic [OUT_POS_W-1:0] data_end;

  modport source (output valid, output tag_index, output data_start, output data_end,
                  input ready);
  modport sink (input valid, input tag_index, input data_start, input data_end,
                output ready);
endinterface

// ===== hdl/rcw_cfg_if.sv =====
// Configuration write channel of the RIFF chunk walker: the file length.
// Widths come from rcw_pkg.
interface rcw_cfg_if;
  import rcw_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] file_length;

  modport source (output valid, output file_length, input ready);
  modport sink (input valid, input file_length, output ready);
endinterface

// ===== hdl/riff_chunk_walker_unit.sv =====
// RIFF chunk walker: takes a RIFF file one byte per beat, checks the outer
// header against the configured file length, walks the chunk tree through the
// top RIFF chunk and INFO lists, and gives one result beat with the tag index
// and data byte range for each chunk whose fourcc is in the tag table. A file
// whose outer header fails gives no results. The block takes one byte every
// clock cycle unless input stalls; a byte waits in the input register, and
// its result, if it has one, is loaded into the result register at the clock
// edge at which the byte leaves the input register for the walker. Input
// stalls only while a byte is held and the result register holds an untaken
// result. The file length register is sampled when the eighth byte of a file
// leaves the input register.
// Depends on rcw_pkg, the three channel interfaces and rcw_walker.
module riff_chunk_walker_unit import rcw_pkg::*; (
  input logic            clk,
  input logic            rst,
  rcw_cfg_if.sink        cfg,
  rcw_byte_if.sink       stream,
  rcw_result_if.source   results
);

  logic             [CFG_W-1:0] file_length;
  logic             in_full;
  logic [7:0]       in_byte;
  logic             advance;
  logic             res_valid;
  rcw_result_t      res;

  // The length register accepts a write in every cycle.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
    end else if (cfg.valid && cfg.ready) begin
      file_length <= cfg.file_length;
    end
  end

  // The held byte moves into the walker whenever the result register is
  // free or is being emptied in this cycle.
  assign advance      = in_full && (!results.valid || results.ready);
  assign stream.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_byte <= stream.data_byte;
    end
  end

  rcw_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .data_byte   (in_byte),
    .file_length (file_length),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register: loaded as each byte is processed, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= res_valid;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      results.tag_index  <= res.tag_index;
      results.data_start <= res.data_start;
      results.data_end   <= res.data_end;
    end
  end

endmodule

// ===== hdl/rcw_tag_lookup.sv =====
// Matches a chunk fourcc against the constant tag table.
// Depends on rcw_pkg for the table and its limits.
module rcw_tag_lookup import rcw_pkg::*; (
  input  logic [31:0]      fourcc,
  output logic             hit,
  output logic [IDX_W-1:0] index
);

  // Scanning from the top down leaves the lowest matching entry in place.
  always_comb begin
    hit   = 1'b0;
    index = '0;
    for (int r = TAG_LIMIT - 1; r >= 0; r--) begin
      if (fourcc == TAG_TABLE[r]) begin
        hit   = 1'b1;
        index = IDX_W'(r);
      end
    end
  end

endmodule

// ===== hdl/rcw_walker.sv =====
// Chunk walk state and per-byte decision logic of the RIFF chunk walker.
// Depends on rcw_pkg, rcw_tag_lookup and assert_macros.svh.
`include "assert_macros.svh"

module rcw_walker import rcw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic [CFG_W-1:0] file_length,
  output logic             res_valid,
  output rcw_result_t      res
);

  localparam logic [1:0] PH_OUTER    = 2'd0;
  localparam logic [1:0] PH_HEADER   = 2'd1;
  localparam logic [1:0] PH_LISTTYPE = 2'd2;
  localparam logic [1:0] PH_DONE     = 2'd3;

  localparam logic [3:0] OFF_SIZE_LAST = 4'd7;
  localparam logic [3:0] OFF_TYPE_LAST = 4'd11;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef addr_t [LEVELS-1:0] levels_t;

  logic [POS_BITS-1:0] byte_position;
  logic [7:0]          header_bytes [HDR_BYTES];
  addr_t               next_header_at;
  levels_t             level_end;
  logic [1:0]          nesting_depth;
  logic [1:0]          walk_phase;

  addr_t      next_header_at_next;
  levels_t    level_end_next;
  logic [1:0] nesting_depth_next;
  logic [1:0] walk_phase_next;

  addr_t      pos_ext;
  addr_t      diff;
  logic       in_window;
  logic [3:0] off;
  logic       active;
  logic [7:0] hv [HDR_BYTES];
  logic [31:0] fourcc;
  logic [31:0] size;
  logic [31:0] list_type;
  addr_t      chunk_end;
  addr_t      level_lim;
  logic       tag_hit;
  logic [IDX_W-1:0] tag_idx;

  addr_t      nha_pre;
  levels_t    le_pre;
  logic [1:0] depth_pre;
  logic       settle_req;
  logic       outer_bad;

  addr_t      nha_s;
  addr_t      lv;
  logic [1:0] d_s;
  logic       stop_s;
  logic       done_s;

  function automatic addr_t pick_level(levels_t le, logic [1:0] d);
    addr_t v;
    unique case (d)
      2'd0:    v = le[0];
      2'd1:    v = le[1];
      default: v = le[2];
    endcase
    return v;
  endfunction

  rcw_tag_lookup u_lookup (
    .fourcc (fourcc),
    .hit    (tag_hit),
    .index  (tag_idx)
  );

  // Where the current byte falls relative to the header being collected.
  always_comb begin
    pos_ext   = addr_t'(byte_position);
    diff      = pos_ext - next_header_at;
    in_window = (pos_ext >= next_header_at) && (diff < addr_t'(HDR_BYTES));
    off       = diff[3:0];
    active    = step && (walk_phase != PH_DONE) && in_window;
    for (int i = 0; i < HDR_BYTES; i++) begin
      hv[i] = (in_window && (off == 4'(i))) ? data_byte : header_bytes[i];
    end
    fourcc    = {hv[0], hv[1], hv[2], hv[3]};
    size      = {hv[7], hv[6], hv[5], hv[4]};
    list_type = {hv[8], hv[9], hv[10], hv[11]};
    chunk_end = next_header_at + addr_t'(8) + addr_t'(size);
  end

  // Header decisions, before levels are closed.
  always_comb begin
    nha_pre         = next_header_at;
    le_pre          = level_end;
    depth_pre       = nesting_depth;
    walk_phase_next = walk_phase;
    settle_req      = 1'b0;
    res_valid       = 1'b0;
    outer_bad       = 1'b0;
    level_lim       = pick_level(level_end, nesting_depth);

    if (active) begin
      unique case (walk_phase) inside
        PH_OUTER, PH_HEADER: begin
          if (off == OFF_SIZE_LAST) begin
            if (walk_phase == PH_OUTER) begin
              if ((file_length < CFG_W'(16)) || (fourcc != FCC_RIFF) ||
                  ({1'b0, size} + 33'd8 != {1'b0, file_length})) begin
                outer_bad       = 1'b1;
                walk_phase_next = PH_DONE;
              end else begin
                le_pre[0]       = addr_t'(file_length);
                depth_pre       = 2'd0;
                walk_phase_next = PH_HEADER;
                level_lim       = addr_t'(file_length);
              end
            end
            if (!outer_bad) begin
              if (chunk_end > level_lim) begin
                // The chunk overruns its level: close the level right away.
                nha_pre    = level_lim;
                settle_req = 1'b1;
              end else if ((depth_pre == 2'd0) && (fourcc == FCC_RIFF) &&
                           (size > 32'd4)) begin
                le_pre[depth_pre + 2'd1] = chunk_end;
                depth_pre  = depth_pre + 2'd1;
                nha_pre    = next_header_at + addr_t'(HDR_BYTES);
                settle_req = 1'b1;
              end else if ((depth_pre < 2'd2) && (fourcc == FCC_LIST) &&
                           (size > 32'd4)) begin
                walk_phase_next = PH_LISTTYPE;
              end else begin
                if ((depth_pre != 2'd0 || fourcc != FCC_RIFF) &&
                    (depth_pre >= 2'd2 || fourcc != FCC_LIST)) begin
                  res_valid = tag_hit;
                end
                nha_pre    = chunk_end + addr_t'(size[0]);
                settle_req = 1'b1;
              end
            end
          end
        end
        PH_LISTTYPE: begin
          if (off == OFF_TYPE_LAST) begin
            walk_phase_next = PH_HEADER;
            if (list_type == FCC_INFO) begin
              if (nesting_depth < 2'd2) begin
                le_pre[nesting_depth + 2'd1] = chunk_end;
                depth_pre  = nesting_depth + 2'd1;
                nha_pre    = next_header_at + addr_t'(HDR_BYTES);
                settle_req = 1'b1;
              end
            end else begin
              nha_pre    = chunk_end + addr_t'(size[0]);
              settle_req = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Close levels until the next header fits; at most one pass per level.
  always_comb begin
    nha_s  = nha_pre;
    d_s    = depth_pre;
    stop_s = !settle_req;
    done_s = 1'b0;
    lv     = '0;
    for (int k = 0; k < LEVELS; k++) begin
      if (!stop_s && !done_s) begin
        lv = pick_level(le_pre, d_s);
        if (nha_s + addr_t'(8) < lv) begin
          stop_s = 1'b1;
        end else if (d_s == 2'd0) begin
          done_s = 1'b1;
        end else begin
          nha_s = lv + addr_t'(lv[0]);
          d_s   = d_s - 2'd1;
        end
      end
    end
    next_header_at_next = nha_s;
    nesting_depth_next  = d_s;
    level_end_next      = le_pre;
  end

  always_comb begin
    res.tag_index  = tag_idx;
    res.data_start = OUT_POS_W'(next_header_at + addr_t'(8));
    res.data_end   = OUT_POS_W'(chunk_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      next_header_at <= '0;
      level_end      <= '0;
      nesting_depth  <= 2'd0;
      walk_phase     <= PH_OUTER;
    end else if (step) begin
      if (byte_position != '1) begin
        byte_position <= byte_position + POS_BITS'(1);
      end
      if (active) begin
        next_header_at <= next_header_at_next;
        level_end      <= level_end_next;
        nesting_depth  <= nesting_depth_next;
        walk_phase     <= done_s ? PH_DONE : walk_phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      header_bytes[off] <= data_byte;
    end
  end

  `RCW_ASSERT_ALWAYS(a_depth_range, clk, rst, nesting_depth != 2'd3)
  `RCW_ASSERT_NEXT(a_done_sticks, clk, rst, walk_phase == PH_DONE, walk_phase == PH_DONE)
  `RCW_ASSERT_SAME(a_range_order, clk, rst, res_valid,
                   (res.data_end >= res.data_start) && (walk_phase != PH_LISTTYPE))
  `RCW_ASSERT_NEXT(a_header_ahead, clk, rst, active && settle_req && !done_s,
                   addr_t'(byte_position) <= next_header_at)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for riff_chunk_walker_unit: streams one generated RIFF file through the byte
// channel and checks every tagged chunk range against a predictor of the chunk walk.
// Depends on rcw_pkg, the three channel interfaces and the walker RTL.
module tb;
  import rcw_pkg::*;

  // Walk phases of the predictor, in the order the walker moves through them.
  typedef enum logic [1:0] {WALK_OUTER, WALK_HEADER, WALK_LIST_TYPE, WALK_DONE} walk_phase_t;

  localparam longint unsigned POS_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - POS_BITS);
  localparam int SIG_TAG       = 0;     // the signature tag, first table entry
  localparam int XMP_TAG       = 1;
  localparam int BODY_TARGET   = 1250;  // top-level chunks are added until the image holds this many bytes
  localparam int SETTLE_CYCLES = 8;     // drain wait for a byte that had no result
  localparam int TAIL_BYTES    = 16;    // bytes sent past the end of the file

  logic clk = 1'b0;
  logic rst;

  rcw_cfg_if    cfg_ch();
  rcw_byte_if   byte_ch();
  rcw_result_if res_ch();

  riff_chunk_walker_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .stream  (byte_ch),
    .results (res_ch)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #(400_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Walk predictor. It keeps its own copy of the length register and of the
  // walker state, and turns each accepted byte into at most one expected range.
  // ---------------------------------------------------------------------------
  logic [31:0]     length_reg;
  longint unsigned walk_pos;
  logic [7:0]      hdr_buf [HDR_BYTES];
  longint unsigned next_hdr;
  longint unsigned lvl_end [LEVELS];
  int              nest;
  walk_phase_t     walk;
  rcw_result_t     pending_tags [$];
  int              mismatches;

  function automatic logic [31:0] hdr_fourcc(input int at);
    return {hdr_buf[at], hdr_buf[at + 1], hdr_buf[at + 2], hdr_buf[at + 3]};
  endfunction

  // Chunk sizes are little-endian on disk.
  function automatic longint unsigned chunk_size();
    return {32'd0, hdr_buf[7], hdr_buf[6], hdr_buf[5], hdr_buf[4]};
  endfunction

  // Close nesting levels until the next header fits in the open one. A header
  // needs more than its 8 bytes left in the level; closing the outermost level
  // ends the walk. A closed level resumes its parent on an even offset.
  function automatic void close_levels();
    while (walk != WALK_DONE) begin
      if (nest > 2) nest = 2;
      if (next_hdr + 8 < lvl_end[nest]) return;
      if (nest == 0) begin
        walk = WALK_DONE;
        return;
      end
      next_hdr = lvl_end[nest] + (lvl_end[nest] & 1);
      nest--;
    end
  endfunction

  function automatic void skip_chunk(input longint unsigned stop, input longint unsigned sz);
    next_hdr = stop + (sz & 1);
    close_levels();
  endfunction

  // Children of a container start after its header and its 4-byte form type.
  function automatic void open_level(input longint unsigned stop);
    if (nest >= 2) return;
    lvl_end[nest + 1] = stop;
    nest++;
    next_hdr += 12;
    close_levels();
  endfunction

  // Decide what a complete 8-byte chunk header means; returns 1 with a range
  // when the chunk fits its level and its fourcc is in the tag table.
  function automatic bit judge_header(output rcw_result_t hit);
    longint unsigned sz;
    longint unsigned start;
    longint unsigned stop;
    logic [31:0]     fcc;
    sz    = chunk_size();
    start = next_hdr;
    stop  = start + 8 + sz;
    fcc   = hdr_fourcc(0);
    hit   = '0;
    // A chunk that runs past its level closes that level right away.
    if (stop > lvl_end[nest]) begin
      next_hdr = lvl_end[nest];
      close_levels();
      return 1'b0;
    end
    if (nest < 1 && fcc == FCC_RIFF) begin
      if (sz > 4) open_level(stop);
      else skip_chunk(stop, sz);
      return 1'b0;
    end
    // A LIST waits for its form type before the walker decides to descend.
    if (nest < 2 && fcc == FCC_LIST) begin
      if (sz > 4) walk = WALK_LIST_TYPE;
      else skip_chunk(stop, sz);
      return 1'b0;
    end
    for (int r = 0; r < TAG_LIMIT; r++) begin
      if (TAG_TABLE[r] == fcc) begin
        hit.tag_index  = IDX_W'(r);
        hit.data_start = OUT_POS_W'(start + 8);
        hit.data_end   = OUT_POS_W'(stop);
        skip_chunk(stop, sz);
        return 1'b1;
      end
    end
    skip_chunk(stop, sz);
    return 1'b0;
  endfunction

  function automatic void track_byte(input logic [7:0] value);
    longint unsigned at;
    longint unsigned off;
    longint unsigned sz;
    rcw_result_t     hit;
    at = walk_pos;
    if (walk_pos < POS_LIMIT) walk_pos++;
    if (walk == WALK_DONE || at < next_hdr) return;
    off = at - next_hdr;
    if (off >= HDR_BYTES) return;
    hdr_buf[off] = value;
    if (walk == WALK_OUTER && off == 7) begin
      // The length register counts only at this byte; later writes do not matter.
      sz = chunk_size();
      if (length_reg < 16 || hdr_fourcc(0) != FCC_RIFF || sz + 8 != length_reg) begin
        walk = WALK_DONE;
        return;
      end
      lvl_end[0] = 64'(length_reg);
      nest = 0;
      walk = WALK_HEADER;
      if (judge_header(hit)) pending_tags.push_back(hit);
    end else if (walk == WALK_HEADER && off == 7) begin
      if (judge_header(hit)) pending_tags.push_back(hit);
    end else if (walk == WALK_LIST_TYPE && off == 11) begin
      sz = chunk_size();
      walk = WALK_HEADER;
      if (hdr_fourcc(8) == FCC_INFO) open_level(next_hdr + 8 + sz);
      else skip_chunk(next_hdr + 8 + sz, sz);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // File image. The whole file is built before the run, because the outer
  // header must carry the total size.
  // ---------------------------------------------------------------------------
  logic [7:0] riff_image [$];
  int         tag_cursor;
  int         file_len;
  int         opening_len;

  function automatic void put_fourcc(input logic [31:0] fcc);
    riff_image.push_back(fcc[31:24]);
    riff_image.push_back(fcc[23:16]);
    riff_image.push_back(fcc[15:8]);
    riff_image.push_back(fcc[7:0]);
  endfunction

  function automatic void put_word_le(input logic [31:0] word);
    riff_image.push_back(word[7:0]);
    riff_image.push_back(word[15:8]);
    riff_image.push_back(word[23:16]);
    riff_image.push_back(word[31:24]);
  endfunction

  function automatic void patch_size(input int at, input logic [31:0] word);
    riff_image[at + 4] = word[7:0];
    riff_image[at + 5] = word[15:8];
    riff_image[at + 6] = word[23:16];
    riff_image[at + 7] = word[31:24];
  endfunction

  // Random chunk payload plus the pad byte that keeps the next header even.
  function automatic void emit_data(input int unsigned n);
    repeat (n) riff_image.push_back(8'($urandom));
    if (n % 2) riff_image.push_back(8'($urandom));
  endfunction

  // Emit the chunks of one nesting level. Most chunks are well formed so the
  // walk reaches the INFO lists; the rest are unknown chunks, short
  // containers, chunks that overrun their level and leftovers too short for a
  // header. The top level runs until the file is long enough.
  function automatic void build_level(input int depth);
    int          count;
    int          n;
    int          pick;
    int          mark;
    int          tag;
    int unsigned len;
    bit          closed;
    count  = $urandom_range(4, 1);
    n      = 0;
    closed = 1'b0;
    while (!closed && ((depth == 0) ? (riff_image.size() < BODY_TARGET) : (n < count))) begin
      n++;
      pick = $urandom_range(99);
      if (pick < 45) begin
        // Walk the table in turn so every tag shows up, with some random picks.
        if ($urandom_range(3) == 0) begin
          tag = $urandom_range(TABLE_SIZE - 1);
        end else begin
          tag = tag_cursor;
          tag_cursor = (tag_cursor + 1) % TABLE_SIZE;
        end
        len = $urandom_range(24);
        put_fourcc(TAG_TABLE[tag]);
        put_word_le(len);
        emit_data(len);
      end else if (pick < 60) begin
        len = $urandom_range(24);
        put_fourcc($urandom);
        put_word_le(len);
        emit_data(len);
      end else if (pick < 67) begin
        // A container too short to hold a form type is skipped whole.
        len = $urandom_range(4);
        put_fourcc((pick % 2) ? FCC_LIST : FCC_RIFF);
        put_word_le(len);
        emit_data(len);
      end else if (pick < 92 && depth < 3) begin
        // A RIFF below the top or a LIST deeper than two is an ordinary chunk;
        // its children are then plain data.
        mark = riff_image.size();
        put_fourcc(($urandom_range(4) == 0) ? FCC_RIFF : FCC_LIST);
        put_word_le(0);
        put_fourcc(($urandom_range(3) == 0) ? 32'($urandom) : FCC_INFO);
        build_level(depth + 1);
        len = riff_image.size() - mark - 8;
        patch_size(mark, len);
        if (len % 2) riff_image.push_back(8'($urandom));
      end else if (depth > 0) begin
        // Overrunning chunk: either far too large or plausibly sized.
        put_fourcc(TAG_TABLE[$urandom_range(TABLE_SIZE - 1)]);
        if ($urandom_range(1)) put_word_le(32'hFFFF_0000 | $urandom_range(16'hFFFF));
        else put_word_le($urandom_range(400, 40));
        repeat ($urandom_range(10, 1)) riff_image.push_back(8'($urandom));
        closed = 1'b1;
      end
    end
    // Leftover shorter than a header; it also makes the container size odd
    // at times.
    if (depth > 0 && $urandom_range(2) == 0) begin
      repeat ($urandom_range(8, 1)) riff_image.push_back(8'($urandom));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers. Everything is driven with nonblocking assignments right
  // after a rising edge and sampled right after the next one, so every check
  // sees the values that were settled before the edge.
  // ---------------------------------------------------------------------------
  int src_idle_pct;
  int sink_idle_pct;

  task automatic write_length(input logic [31:0] value);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.file_length <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    length_reg = value;
    @(posedge clk);
  endtask

  // Send one byte and predict its effect on the beat that takes it.
  task automatic push_byte(input logic [7:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= value;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    track_byte(value);
  endtask

  task automatic stream_bytes(input int first, input int last);
    for (int i = first; i < last; i++) push_byte(riff_image[i]);
    byte_ch.valid <= 1'b0;
  endtask

  // Wait until every expected range has come back, then give a byte that had
  // no result time to clear the pipeline.
  task automatic drain_results();
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t: %s", $time, msg);
  endtask

  // Result side: random back-pressure, and every beat checked against the
  // oldest expected range.
  always @(posedge clk) begin : take_results
    rcw_result_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_tags.size() == 0) begin
          report_mismatch($sformatf("unexpected result: tag %0d range %0d..%0d",
                                    res_ch.tag_index, res_ch.data_start, res_ch.data_end));
        end else begin
          want = pending_tags.pop_front();
          if (res_ch.tag_index !== want.tag_index)
            report_mismatch($sformatf("tag_index got %0d want %0d",
                                      res_ch.tag_index, want.tag_index));
          if (res_ch.data_start !== want.data_start)
            report_mismatch($sformatf("data_start got %0d want %0d",
                                      res_ch.data_start, want.data_start));
          if (res_ch.data_end !== want.data_end)
            report_mismatch($sformatf("data_end got %0d want %0d",
                                      res_ch.data_end, want.data_end));
        end
      end
      res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests. A finished walk only ends with reset, so the whole run is one file:
  // the tests below cover successive stretches of it.
  // ---------------------------------------------------------------------------

  // Both extremes of the length register go in before the real file length.
  task automatic test_length_register();
    write_length('0);
    write_length('1);
    write_length(file_len);
  endtask

  // Outer header, a signature chunk with no data and an XMP chunk with one
  // all-ones byte and an all-zeros pad.
  task automatic test_opening_chunks();
    src_idle_pct  = 33;
    sink_idle_pct = 58;
    stream_bytes(0, opening_len);
    drain_results();
  endtask

  // The random chunk tree in three stretches with different pacing. Length
  // writes in between must not disturb the walk under way.
  task automatic test_random_walk();
    int cut1;
    int cut2;
    cut1 = opening_len + (file_len - opening_len) / 3;
    cut2 = opening_len + 2 * (file_len - opening_len) / 3;
    stream_bytes(opening_len, cut1);
    drain_results();
    write_length($urandom);
    src_idle_pct  = 58;
    sink_idle_pct = 33;
    stream_bytes(cut1, cut2);
    drain_results();
    write_length(16);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    stream_bytes(cut2, file_len);
    drain_results();
  endtask

  // Bytes past the end of the walk are ignored.
  task automatic test_bytes_after_end();
    write_length('1);
    stream_bytes(file_len, riff_image.size());
    drain_results();
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.file_length <= '0;
    byte_ch.valid      <= 1'b0;
    byte_ch.data_byte  <= '0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    mismatches    = 0;
    tag_cursor    = 0;

    // Predictor state after reset.
    length_reg = '0;
    walk_pos   = 0;
    next_hdr   = 0;
    nest       = 0;
    walk       = WALK_OUTER;
    foreach (hdr_buf[i]) hdr_buf[i] = '0;
    foreach (lvl_end[i]) lvl_end[i] = 0;

    // Outer header with the size patched in below, then the opening chunks.
    put_fourcc(FCC_RIFF);
    put_word_le(0);
    put_fourcc("WAVE");
    put_fourcc(TAG_TABLE[SIG_TAG]);
    put_word_le(0);
    put_fourcc(TAG_TABLE[XMP_TAG]);
    put_word_le(1);
    riff_image.push_back(8'hFF);
    riff_image.push_back(8'h00);
    opening_len = riff_image.size();
    build_level(0);
    // The file ends either in a leftover too short for a header or in a chunk
    // that overruns the file; both end the walk.
    if ($urandom_range(1)) begin
      repeat ($urandom_range(8, 1)) riff_image.push_back(8'($urandom));
    end else begin
      put_fourcc(TAG_TABLE[$urandom_range(TABLE_SIZE - 1)]);
      put_word_le(32'hFFFF_0000 | $urandom_range(16'hFFFF));
      repeat ($urandom_range(6, 1)) riff_image.push_back(8'($urandom));
    end
    file_len = riff_image.size();
    patch_size(0, file_len - 8);
    repeat (TAIL_BYTES) riff_image.push_back(8'($urandom));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_length_register();
    test_opening_chunks();
    test_random_walk();
    test_bytes_after_end();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== riff_chunk_walker_unit.f =====
+incdir+hdl
hdl/rcw_pkg.sv
hdl/rcw_byte_if.sv
hdl/rcw_result_if.sv
hdl/rcw_cfg_if.sv
hdl/rcw_tag_lookup.sv
hdl/rcw_walker.sv
hdl/riff_chunk_walker_unit.sv
tb/tb.sv
